// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the change detector.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define VSCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that, when true, must be followed by another in the next cycle.
`define VSCD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hw/rtl/vscd_pkg.sv =====
// Package for the vital-sign change detector: request kinds, register
// indexes, reset values and the structs passed between modules. No dependencies.
package vscd_pkg;

  // Request kinds carried on in_tuser.
  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_CONSUME = 2'd1;
  localparam logic [1:0] KIND_REPORT  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEART_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BREATH_STEP = 3'd4;

  // Register reset values (rate steps are Q8.4: 3.0 and 2.0).
  localparam logic [31:0] MAX_AGE_RST     = 32'd5000;
  localparam logic [7:0]  MOVE_STEP_RST   = 8'd5;
  localparam logic [15:0] DIST_STEP_RST   = 16'd10;
  localparam logic [11:0] HEART_STEP_RST  = 12'd48;
  localparam logic [11:0] BREATH_STEP_RST = 12'd32;

  // Bus widths.
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 48;

  // Change mask bit positions.
  localparam int MB_PRESENCE = 0;
  localparam int MB_MOTION   = 1;
  localparam int MB_SLEEP    = 2;
  localparam int MB_MOVE     = 3;
  localparam int MB_DIST     = 4;
  localparam int MB_HEART    = 5;
  localparam int MB_BREATH   = 6;
  localparam int MB_ABNORMAL = 7;

  typedef struct packed {
    logic [31:0] max_age;
    logic [7:0]  move_step;
    logic [15:0] dist_step;
    logic [11:0] heart_step;
    logic [11:0] breath_step;
  } cfg_t;

  // Sensor readings as held for the latest sample.
  typedef struct packed {
    logic [11:0] heart;
    logic [11:0] breath;
    logic [15:0] distance;
    logic [7:0]  presence;
    logic [7:0]  motion;
    logic [7:0]  sleep_state;
    logic [7:0]  body_move;
    logic [7:0]  abnormal;
    logic        heart_ok;
    logic        breath_ok;
  } reading_t;

  // Snapshot kept at the last consume request.
  typedef struct packed {
    logic [11:0] heart;
    logic [11:0] breath;
    logic [15:0] distance;
    logic [7:0]  presence;
    logic [7:0]  motion;
    logic [7:0]  sleep_state;
    logic [7:0]  body_move;
    logic [7:0]  abnormal;
  } snap_t;

  typedef struct packed {
    logic [1:0]  kind;
    reading_t    rd;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [7:0]  change_mask;
    logic        changed;
    logic        occupant;
    logic        in_bed;
    logic        vitals_ok;
    logic        fresh;
    logic [31:0] sample_age;
  } report_t;

endpackage

// ===== hw/rtl/vscd_core.sv =====
// State and report logic of the change detector: latest readings, kept
// snapshot and the per-request report. Depends on vscd_pkg.
module vscd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  vscd_pkg::item_t item,
  input  vscd_pkg::cfg_t  cfg,
  output vscd_pkg::report_t rep
);
  import vscd_pkg::*;

  reading_t    lat_r, lat_nxt;
  snap_t       kept_r, kept_nxt;
  logic [31:0] stime_r, stime_nxt;
  logic        seen_r, seen_nxt;
  logic        kept_vld_r, kept_vld_nxt;
  logic [7:0]  mask;
  logic [32:0] age_diff;

  // True when |a - b| >= step, all values zero-extended to 16 bits.
  function automatic logic gap_reached(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] step);
    logic [15:0] gap;
    gap = (a >= b) ? (a - b) : (b - a);
    return gap >= step;
  endfunction

  // Next state for the request being processed.
  always_comb begin
    lat_nxt      = lat_r;
    kept_nxt     = kept_r;
    stime_nxt    = stime_r;
    seen_nxt     = seen_r;
    kept_vld_nxt = kept_vld_r;
    if (en) begin
      case (item.kind)
        KIND_SAMPLE: begin
          lat_nxt   = item.rd;
          stime_nxt = item.now_ms;
          seen_nxt  = 1'b1;
        end
        KIND_CONSUME: begin
          kept_nxt.heart       = lat_r.heart;
          kept_nxt.breath      = lat_r.breath;
          kept_nxt.distance    = lat_r.distance;
          kept_nxt.presence    = lat_r.presence;
          kept_nxt.motion      = lat_r.motion;
          kept_nxt.sleep_state = lat_r.sleep_state;
          kept_nxt.body_move   = lat_r.body_move;
          kept_nxt.abnormal    = lat_r.abnormal;
          kept_vld_nxt         = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r      <= '0;
      kept_r     <= '0;
      stime_r    <= '0;
      seen_r     <= 1'b0;
      kept_vld_r <= 1'b0;
    end else begin
      lat_r      <= lat_nxt;
      kept_r     <= kept_nxt;
      stime_r    <= stime_nxt;
      seen_r     <= seen_nxt;
      kept_vld_r <= kept_vld_nxt;
    end
  end

  // Change flags against the kept snapshot, using the state after this request.
  always_comb begin
    mask = '0;
    mask[MB_PRESENCE] = lat_nxt.presence != kept_nxt.presence;
    mask[MB_MOTION]   = lat_nxt.motion != kept_nxt.motion;
    mask[MB_SLEEP]    = lat_nxt.sleep_state != kept_nxt.sleep_state;
    mask[MB_MOVE]     = gap_reached({8'd0, lat_nxt.body_move}, {8'd0, kept_nxt.body_move},
                                    {8'd0, cfg.move_step});
    mask[MB_DIST]     = gap_reached(lat_nxt.distance, kept_nxt.distance, cfg.dist_step);
    mask[MB_HEART]    = gap_reached({4'd0, lat_nxt.heart}, {4'd0, kept_nxt.heart},
                                    {4'd0, cfg.heart_step});
    mask[MB_BREATH]   = gap_reached({4'd0, lat_nxt.breath}, {4'd0, kept_nxt.breath},
                                    {4'd0, cfg.breath_step});
    mask[MB_ABNORMAL] = lat_nxt.abnormal != kept_nxt.abnormal;
  end

  // Sample age: the borrow bit of the subtraction says time is behind the sample.
  assign age_diff = {1'b0, item.now_ms} - {1'b0, stime_nxt};

  always_comb begin
    rep.change_mask = kept_vld_nxt ? mask : 8'd0;
    rep.changed     = kept_vld_nxt ? (|mask) : seen_nxt;
    rep.occupant    = lat_nxt.presence != 8'd0;
    rep.in_bed      = (lat_nxt.presence != 8'd0) || (lat_nxt.sleep_state != 8'd0);
    rep.vitals_ok   = lat_nxt.heart_ok || lat_nxt.breath_ok;
    rep.sample_age  = '0;
    rep.fresh       = 1'b0;
    if (seen_nxt && !age_diff[32]) begin
      rep.sample_age = age_diff[31:0];
      rep.fresh      = age_diff[31:0] <= cfg.max_age;
    end
  end

endmodule

// ===== hw/rtl/vital_sign_change_detector.sv =====
// Vital-sign change detector: one report for every request, filtered against
// a consumed snapshot with per-field deadbands. The block takes one request
// per clock cycle while out_tready does not stall it, and returns its report
// through the input register, then through the state update and report logic
// into the result register. Stalls on out_tready back up through both
// registers; configuration writes take effect on the next cycle and are
// meant to be made while no request is in flight. Depends on vscd_pkg and
// vscd_core.
`include "assert_macros.svh"

module vital_sign_change_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Request channel.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata, low bit up: heart[12], breath[12], distance[16],
  // presence[8], motion[8], sleep_state[8], movement[8],
  // abnormal[8], heart_ok[1], breath_ok[1], now_ms[32], zero fill.
  input  logic [vscd_pkg::IN_DATA_W-1:0]       in_tdata,
  // tuser: kind[2].
  input  logic [1:0]                           in_tuser,
  // Report channel.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata, low bit up: change_mask[8], changed[1], occupant[1],
  // in_bed[1], vitals_ok[1], fresh[1], sample_age[32], zero fill.
  output logic [vscd_pkg::OUT_DATA_W-1:0]      out_tdata,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [vscd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vscd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import vscd_pkg::*;

  cfg_t    cfg_r;
  item_t   item_r, item_in;
  logic    s1_valid_r;
  logic    out_valid_r;
  report_t rep, rep_r;
  logic    advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_age     <= MAX_AGE_RST;
      cfg_r.move_step   <= MOVE_STEP_RST;
      cfg_r.dist_step   <= DIST_STEP_RST;
      cfg_r.heart_step  <= HEART_STEP_RST;
      cfg_r.breath_step <= BREATH_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_AGE:     cfg_r.max_age     <= cfg_data;
        REG_MOVE_STEP:   cfg_r.move_step   <= cfg_data[7:0];
        REG_DIST_STEP:   cfg_r.dist_step   <= cfg_data[15:0];
        REG_HEART_STEP:  cfg_r.heart_step  <= cfg_data[11:0];
        REG_BREATH_STEP: cfg_r.breath_step <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the request bus.
  always_comb begin
    item_in.kind           = in_tuser;
    item_in.rd.heart       = in_tdata[11:0];
    item_in.rd.breath      = in_tdata[23:12];
    item_in.rd.distance    = in_tdata[39:24];
    item_in.rd.presence    = in_tdata[47:40];
    item_in.rd.motion      = in_tdata[55:48];
    item_in.rd.sleep_state = in_tdata[63:56];
    item_in.rd.body_move   = in_tdata[71:64];
    item_in.rd.abnormal    = in_tdata[79:72];
    item_in.rd.heart_ok    = in_tdata[80];
    item_in.rd.breath_ok   = in_tdata[81];
    item_in.now_ms         = in_tdata[113:82];
  end

  // Pipeline moves when the result register is free or being drained.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_in;
    end
  end

  vscd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_valid_r && advance),
    .item  (item_r),
    .cfg   (cfg_r),
    .rep   (rep)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      rep_r <= rep;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, rep_r.sample_age, rep_r.fresh,
                       rep_r.vitals_ok, rep_r.in_bed, rep_r.occupant,
                       rep_r.changed, rep_r.change_mask};

  // Checks on the report and the pipeline control.
  `VSCD_ASSERT(a_mask_implies_any, !out_valid_r || rep_r.change_mask == 8'd0 || rep_r.changed, "change flag set without the changed bit")
  `VSCD_ASSERT(a_person_in_bed, !out_valid_r || !rep_r.occupant || rep_r.in_bed, "person present but bed not occupied")
  `VSCD_ASSERT(a_fresh_age, !out_valid_r || !rep_r.fresh || rep_r.sample_age <= cfg_r.max_age, "fresh sample older than limit")
  `VSCD_ASSERT_NEXT(a_stage_holds, s1_valid_r && !advance, s1_valid_r && $stable(item_r), "input stage lost a stalled request")

endmodule

// ===== dv/vital_sign_change_detector_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for vital_sign_change_detector: a report predictor
// in a small scoreboard class, random stream traffic with stalls on both sides.
// Depends on vscd_pkg and the RTL of the block only.

module vital_sign_change_detector_test;
  import vscd_pkg::*;

  // One report, field by field, as the predictor works it out.
  typedef struct packed {
    logic [7:0]  change_mask;
    logic        changed;
    logic        occupant;
    logic        in_bed;
    logic        vitals_ok;
    logic        fresh;
    logic [31:0] sample_age;
  } report_fields_t;

  // Predicts the report of every accepted request and checks returned reports.
  class change_report_board;
    cfg_t           cfg;
    reading_t       latest;
    logic [31:0]    sample_time;
    bit             sample_seen;
    snap_t          kept;
    bit             kept_valid;
    report_fields_t pending_reports[$];
    int             error_count;

    function new();
      cfg.max_age     = MAX_AGE_RST;
      cfg.move_step   = MOVE_STEP_RST;
      cfg.dist_step   = DIST_STEP_RST;
      cfg.heart_step  = HEART_STEP_RST;
      cfg.breath_step = BREATH_STEP_RST;
      latest          = '0;
      sample_time     = '0;
      sample_seen     = 1'b0;
      kept            = '0;
      kept_valid      = 1'b0;
      error_count     = 0;
    endfunction

    // Register writes are truncated to the width of each register.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_MAX_AGE:     cfg.max_age = value;
        REG_MOVE_STEP:   cfg.move_step = value[7:0];
        REG_DIST_STEP:   cfg.dist_step = value[15:0];
        REG_HEART_STEP:  cfg.heart_step = value[11:0];
        REG_BREATH_STEP: cfg.breath_step = value[11:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] gap(logic [31:0] a, logic [31:0] b);
      return (a >= b) ? a - b : b - a;
    endfunction

    // Updates the stored state for one request and queues its report.
    function void note_request(item_t req);
      report_fields_t rep;
      rep = '0;
      if (req.kind == KIND_SAMPLE) begin
        latest = req.rd;
        sample_time = req.now_ms;
        sample_seen = 1'b1;
      end else if (req.kind == KIND_CONSUME) begin
        kept.heart       = latest.heart;
        kept.breath      = latest.breath;
        kept.distance    = latest.distance;
        kept.presence    = latest.presence;
        kept.motion      = latest.motion;
        kept.sleep_state = latest.sleep_state;
        kept.body_move   = latest.body_move;
        kept.abnormal    = latest.abnormal;
        kept_valid = 1'b1;
      end

      // Change flags exist only once a snapshot has been consumed.
      if (kept_valid) begin
        rep.change_mask[MB_PRESENCE] = latest.presence != kept.presence;
        rep.change_mask[MB_MOTION]   = latest.motion != kept.motion;
        rep.change_mask[MB_SLEEP]    = latest.sleep_state != kept.sleep_state;
        rep.change_mask[MB_MOVE]     = gap(32'(latest.body_move), 32'(kept.body_move))
                                       >= 32'(cfg.move_step);
        rep.change_mask[MB_DIST]     = gap(32'(latest.distance), 32'(kept.distance))
                                       >= 32'(cfg.dist_step);
        rep.change_mask[MB_HEART]    = gap(32'(latest.heart), 32'(kept.heart))
                                       >= 32'(cfg.heart_step);
        rep.change_mask[MB_BREATH]   = gap(32'(latest.breath), 32'(kept.breath))
                                       >= 32'(cfg.breath_step);
        rep.change_mask[MB_ABNORMAL] = latest.abnormal != kept.abnormal;
        rep.changed = |rep.change_mask;
      end else begin
        rep.changed = sample_seen;
      end

      rep.occupant  = latest.presence != 8'd0;
      rep.in_bed    = (latest.presence != 8'd0) || (latest.sleep_state != 8'd0);
      rep.vitals_ok = latest.heart_ok | latest.breath_ok;

      // Age is zero when no sample exists or the clock is behind the sample.
      if (sample_seen && req.now_ms >= sample_time) begin
        rep.sample_age = req.now_ms - sample_time;
        rep.fresh = rep.sample_age <= cfg.max_age;
      end
      pending_reports.push_back(rep);
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // Compares one returned report with the oldest prediction.
    function void check_report(logic [OUT_DATA_W-1:0] data);
      report_fields_t want;
      bit ok;
      if (pending_reports.size() == 0) begin
        $display("%0t: report with no request pending, expected none, actual %h",
                 $time, data);
        error_count++;
        return;
      end
      want = pending_reports.pop_front();
      ok = 1'b1;
      ok &= field_ok("change_mask", 32'(want.change_mask), 32'(data[7:0]));
      ok &= field_ok("changed", 32'(want.changed), 32'(data[8]));
      ok &= field_ok("occupant", 32'(want.occupant), 32'(data[9]));
      ok &= field_ok("in_bed", 32'(want.in_bed), 32'(data[10]));
      ok &= field_ok("vitals_ok", 32'(want.vitals_ok), 32'(data[11]));
      ok &= field_ok("fresh", 32'(want.fresh), 32'(data[12]));
      ok &= field_ok("sample_age", want.sample_age, data[44:13]);
      if (!ok) error_count++;
    endfunction
  endclass

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  change_report_board board;
  bit          hold_request = 1'b0;
  bit          burst_mode = 1'b0;
  reading_t    gen_base = '0;
  logic [31:0] gen_time = '0;
  logic [31:0] gen_sample_time = '0;

  vital_sign_change_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("vital_sign_change_detector verification failed");
    $finish;
  end

  // Every accepted report is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_report(out_tdata);
  end

  // Report receiver: random stalls, bursts without stalls and long hold-offs on request.
  initial begin : receiver
    int stall;
    wait (rst_n);
    forever begin
      if (hold_request) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = burst_mode ? 0 : $urandom_range(0, 6);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic item_t item_of(logic [1:0] kind, logic [31:0] heart,
                                    logic [31:0] breath, logic [31:0] dst,
                                    logic [31:0] pres, logic [31:0] mot, logic [31:0] slp,
                                    logic [31:0] mov, logic [31:0] abn, logic [31:0] hv,
                                    logic [31:0] bv, logic [31:0] now);
    item_t r;
    r.kind = kind;
    r.rd.heart = heart[11:0];
    r.rd.breath = breath[11:0];
    r.rd.distance = dst[15:0];
    r.rd.presence = pres[7:0];
    r.rd.motion = mot[7:0];
    r.rd.sleep_state = slp[7:0];
    r.rd.body_move = mov[7:0];
    r.rd.abnormal = abn[7:0];
    r.rd.heart_ok = hv[0];
    r.rd.breath_ok = bv[0];
    r.now_ms = now;
    return r;
  endfunction

  // A reading near the last sample, often around the deadband edge.
  function automatic logic [31:0] nudge(logic [31:0] base, logic [31:0] step);
    logic [31:0] offset;
    case ($urandom_range(0, 3))
      0: offset = step - 1;
      1: offset = step;
      2: offset = step + 1;
      default: offset = $urandom_range(0, step + 1);
    endcase
    case ($urandom_range(0, 5))
      0, 1: return base;
      2, 3: return base + offset;
      4: return base - offset;
      default: return $urandom;
    endcase
  endfunction

  // A state code that mostly repeats the last one.
  function automatic logic [7:0] code_pick(logic [7:0] base);
    case ($urandom_range(0, 3))
      0, 1: return base;
      2: return 8'($urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  // Time of a request: mostly moving forward, sometimes on the freshness edge
  // or behind the stored sample.
  function automatic logic [31:0] next_now();
    logic [31:0] t;
    case ($urandom_range(0, 9))
      0: t = gen_sample_time + board.cfg.max_age;
      1: t = gen_sample_time + board.cfg.max_age + 1;
      2: return gen_sample_time - $urandom_range(1, 500);
      3: t = $urandom;
      default: t = gen_time + $urandom_range(0, 2500);
    endcase
    gen_time = t;
    return t;
  endfunction

  function automatic item_t random_item();
    logic [127:0] noise;
    item_t r;
    int pick;
    noise = {$urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(item_t)-1:0];
    pick = $urandom_range(0, 99);
    // Fully random requests, any kind.
    if (pick < 8) begin
      r.kind = 2'($urandom_range(0, 3));
      return r;
    end
    r.now_ms = next_now();
    if (pick < 52) begin
      r.kind = KIND_SAMPLE;
      r.rd.heart = 12'(nudge(32'(gen_base.heart), 32'(board.cfg.heart_step)));
      r.rd.breath = 12'(nudge(32'(gen_base.breath), 32'(board.cfg.breath_step)));
      r.rd.distance = 16'(nudge(32'(gen_base.distance), 32'(board.cfg.dist_step)));
      r.rd.body_move = 8'(nudge(32'(gen_base.body_move), 32'(board.cfg.move_step)));
      r.rd.presence = code_pick(gen_base.presence);
      r.rd.motion = code_pick(gen_base.motion);
      r.rd.sleep_state = code_pick(gen_base.sleep_state);
      r.rd.abnormal = code_pick(gen_base.abnormal);
    end else if (pick < 70) begin
      r.kind = KIND_CONSUME;
    end else if (pick < 95) begin
      r.kind = KIND_REPORT;
    end else begin
      r.kind = KIND_UNUSED;
    end
    return r;
  endfunction

  // Offers one request after a random gap and waits for its acceptance.
  task automatic send_item(input item_t req);
    int idle;
    logic [IN_DATA_W-1:0] word;
    idle = burst_mode ? 0 : $urandom_range(0, 6);
    word = '0;
    word[11:0]   = req.rd.heart;
    word[23:12]  = req.rd.breath;
    word[39:24]  = req.rd.distance;
    word[47:40]  = req.rd.presence;
    word[55:48]  = req.rd.motion;
    word[63:56]  = req.rd.sleep_state;
    word[71:64]  = req.rd.body_move;
    word[79:72]  = req.rd.abnormal;
    word[80]     = req.rd.heart_ok;
    word[81]     = req.rd.breath_ok;
    word[113:82] = req.now_ms;
    repeat (idle) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= word;
    in_tuser <= req.kind;
    do @(posedge clk); while (!in_tready);
    board.note_request(req);
    if (req.kind == KIND_SAMPLE) begin
      gen_base = req.rd;
      gen_sample_time = req.now_ms;
      gen_time = req.now_ms;
    end
  endtask

  // Stops offering and waits until every predicted report has returned.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    board.set_reg(idx, value);
  endtask

  // Writes all registers, plus one unused index above the last, while the block is idle.
  task automatic configure(input logic [31:0] age, input logic [31:0] move,
                           input logic [31:0] dst, input logic [31:0] heart,
                           input logic [31:0] breath);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_MAX_AGE, age);
    write_reg(REG_MOVE_STEP, move);
    write_reg(REG_DIST_STEP, dst);
    write_reg(REG_HEART_STEP, heart);
    write_reg(REG_BREATH_STEP, breath);
    write_reg(CFG_IDX_W'(REG_BREATH_STEP + 1 + $urandom_range(0, 2)), $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Directed requests under the reset settings.
  task automatic run_directed();
    // Report before any sample, then a consume of the reset values.
    send_item(item_of(KIND_REPORT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(KIND_CONSUME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(KIND_REPORT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // A sample taken at time zero still counts as seen.
    send_item(item_of(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(KIND_REPORT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // All fields at their maximum.
    send_item(item_of(KIND_SAMPLE, 'hFFF, 'hFFF, 'hFFFF, 'hFF, 'hFF, 'hFF,
                      'hFF, 'hFF, 1, 1, 32'hFFFF_FFFF));
    send_item(item_of(KIND_CONSUME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    // Clock behind the stored sample.
    send_item(item_of(KIND_REPORT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Differences just under, then exactly at, the default deadbands.
    send_item(item_of(KIND_SAMPLE, 'hFFF - 47, 'hFFF - 31, 'hFFFF - 9, 'hFF,
                      'hFF, 'hFF, 'hFF - 4, 'hFF, 1, 0, 100));
    send_item(item_of(KIND_SAMPLE, 'hFFF - 48, 'hFFF - 32, 'hFFFF - 10, 'hFF,
                      'hFF, 'hFF, 'hFF - 5, 'hFF, 0, 1, 200));
    // Age on both sides of the freshness limit.
    send_item(item_of(KIND_REPORT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5200));
    send_item(item_of(KIND_REPORT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5201));
    // In bed through the sleep state alone, no valid vitals.
    send_item(item_of(KIND_SAMPLE, 'h4B0, 'h0F0, 300, 'h00, 'h02, 'h03,
                      'h10, 'h00, 0, 0, 6000));
    // The unused kind only reports.
    send_item(item_of(KIND_UNUSED, 'h5A5, 'hA5A, 'h1234, 'h55, 'hAA, 'h0F,
                      'hF0, 'h3C, 1, 0, 6001));
    send_item(item_of(KIND_CONSUME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 6002));
    // Code changes against the fresh snapshot.
    send_item(item_of(KIND_SAMPLE, 'h4B0, 'h0F0, 300, 'h01, 'h07, 'h00,
                      'h10, 'h09, 1, 1, 6100));
    send_item(item_of(KIND_REPORT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 199));
  endtask

  // Random requests with an optional hold-off, drain pause and burst window.
  task automatic run_random(input int count, input int hold_at, input int drain_at,
                            input int burst_from, input int burst_to);
    for (int i = 0; i < count; i++) begin
      burst_mode = (i >= burst_from) && (i < burst_to);
      if (i == hold_at) hold_request = 1'b1;
      if (i == drain_at) wait_drained();
      send_item(random_item());
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    board = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(315, -1, -1, 100, 160);

    // Zero deadbands and zero freshness window.
    configure(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_random(315, 100, -1, -1, -1);

    // Every register at its maximum.
    configure(32'hFFFF_FFFF, 32'hFF, 32'hFFFF, 32'hFFF, 32'hFFF);
    run_random(315, -1, 150, 200, 260);

    configure($urandom_range(0, 20000), $urandom_range(0, 40), $urandom_range(0, 300),
              $urandom_range(0, 200), $urandom_range(0, 200));
    run_random(315, 50, 200, -1, -1);

    // Junk above each register width must be dropped.
    configure($urandom, ($urandom & 32'hFFFF_FF00) | 32'd3,
              ($urandom & 32'hFFFF_0000) | 32'd20, ($urandom & 32'hFFFF_F000) | 32'd16,
              ($urandom & 32'hFFFF_F000) | 32'd64);
    run_random(315, -1, 100, 150, 250);

    configure(MAX_AGE_RST, 32'(MOVE_STEP_RST), 32'(DIST_STEP_RST), 32'(HEART_STEP_RST),
              32'(BREATH_STEP_RST));
    run_random(315, 200, -1, -1, -1);

    wait_drained();
    repeat (20) @(posedge clk);
    if (board.error_count == 0 && board.pending_reports.size() == 0) begin
      $display("vital_sign_change_detector verification clean");
    end else begin
      $display("vital_sign_change_detector verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vscd_pkg.sv
hw/rtl/vscd_core.sv
hw/rtl/vital_sign_change_detector.sv
dv/vital_sign_change_detector_test.sv
